// ----- rtl/scgs_pkg.sv -----
// Shared constants, codes and control structs for the signed codebook gather-sum block.
package scgs_pkg;

  // Store geometry
  localparam int ROWS  = 64;
  localparam int SLOTS = 16;
  localparam int ATOMS = 1024;

  // Field widths
  localparam int ROW_W   = 6;
  localparam int SLOT_W  = 4;
  localparam int ATOM_W  = 10;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int ATOMS_CFG_W  = 11;
  localparam int SLOTS_CFG_W  = 5;
  localparam int ATOMS_RESET  = 1024;
  localparam int SLOTS_RESET  = 16;

  // Datapath widths
  localparam int CODE_AW = ROW_W + SLOT_W;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int SUM_W   = VAL_W + $clog2(SLOTS) + 1;
  localparam int ABS_W   = SUM_W - 1;
  localparam int FRAC_W  = 16;
  localparam int HI_W    = ABS_W - FRAC_W;
  localparam int MAG_W   = ABS_W + FRAC_W;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CODE    = 2'd0,
    KIND_SCALE   = 2'd1,
    KIND_PROJ    = 2'd2,
    KIND_COMPUTE = 2'd3
  } scgs_kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATOMS    = 2'd0,
    CFG_SLOTS    = 2'd1,
    CFG_SCALE_EN = 2'd2
  } scgs_cfg_e;

  // Sequencer to scale unit
  typedef struct packed {
    logic start;
    logic ack;
    logic scale_en;
  } scgs_scale_req_t;

  // Scale unit to sequencer
  typedef struct packed {
    logic done;
  } scgs_scale_rsp_t;

endpackage

// ----- rtl/scgs_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface scgs_in_if;
  import scgs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ROW_W-1:0]         out_row;
  logic [SLOT_W-1:0]        slot;
  logic signed [CODE_W-1:0] code_value;
  logic [ATOM_W-1:0]        atom_index;
  logic signed [VAL_W-1:0]  proj_value;
  logic signed [VAL_W-1:0]  scale_value;

  modport source (
    output valid, kind, out_row, slot, code_value, atom_index, proj_value, scale_value,
    input  ready
  );
  modport sink (
    input  valid, kind, out_row, slot, code_value, atom_index, proj_value, scale_value,
    output ready
  );
endinterface

interface scgs_out_if;
  import scgs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row;
  logic signed [VAL_W-1:0] sum_value;

  modport source (
    output valid, row, sum_value,
    input  ready
  );
  modport sink (
    input  valid, row, sum_value,
    output ready
  );
endinterface

// ----- rtl/scgs_scaler.sv -----
// Scale unit: sign split, shared multiplier over two passes, rounding and Q16.16 saturation.
module scgs_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scgs_pkg::scgs_scale_req_t         req_i,
  input  logic signed [scgs_pkg::SUM_W-1:0] sum_i,
  input  logic signed [scgs_pkg::VAL_W-1:0] scale_i,
  output scgs_pkg::scgs_scale_rsp_t         rsp_o,
  output logic [scgs_pkg::VAL_W-1:0]        result_o
);
  import scgs_pkg::*;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL_LO,
    SC_MUL_HI,
    SC_ADD,
    SC_SAT,
    SC_DONE
  } sc_state_e;

  sc_state_e          st_q;
  logic               neg_q;
  logic               sneg_q;
  logic [MAG_W-1:0]   mag_q;
  logic [VAL_W-1:0]   smag_q;
  logic [MAG_W-1:0]   prod_q;
  logic [MAG_W-1:0]   rnd_q;
  logic [VAL_W-1:0]   result_q;

  logic [SUM_W-1:0]   sum_abs;
  logic [VAL_W-1:0]   scale_abs;
  logic [HI_W-1:0]    mul_a;
  logic [MAG_W-1:0]   mul_p;
  logic [VAL_W-1:0]   sat_val;

  // Magnitudes of the incoming operands
  assign sum_abs   = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign scale_abs = scale_i[VAL_W-1] ? (~scale_i + 1'b1) : scale_i;

  // Shared multiplier: low 16 bits of the magnitude first, then the high part
  assign mul_a = (st_q == SC_MUL_LO) ? HI_W'(mag_q[FRAC_W-1:0]) : mag_q[ABS_W-1:FRAC_W];
  assign mul_p = MAG_W'(mul_a) * MAG_W'(smag_q);

  // Saturate to signed 32 bits; a zero magnitude is positive
  always_comb begin
    if (neg_q && (mag_q != '0)) begin
      if (mag_q >= MAG_W'(64'h8000_0000)) begin
        sat_val = 32'h8000_0000;
      end else begin
        sat_val = ~mag_q[VAL_W-1:0] + 1'b1;
      end
    end else if (mag_q > MAG_W'(64'h7FFF_FFFF)) begin
      sat_val = 32'h7FFF_FFFF;
    end else begin
      sat_val = mag_q[VAL_W-1:0];
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SC_IDLE;
      neg_q    <= 1'b0;
      sneg_q   <= 1'b0;
      mag_q    <= '0;
      smag_q   <= '0;
      prod_q   <= '0;
      rnd_q    <= '0;
      result_q <= '0;
    end else begin
      case (st_q)
        SC_IDLE: begin
          if (req_i.start) begin
            neg_q  <= sum_i[SUM_W-1];
            mag_q  <= MAG_W'(sum_abs);
            sneg_q <= scale_i[VAL_W-1];
            smag_q <= scale_abs;
            st_q   <= req_i.scale_en ? SC_MUL_LO : SC_SAT;
          end
        end
        SC_MUL_LO: begin
          prod_q <= mul_p;
          st_q   <= SC_MUL_HI;
        end
        SC_MUL_HI: begin
          // round the low partial product to nearest, ties up on the magnitude
          rnd_q  <= (prod_q + MAG_W'(32'h8000)) >> FRAC_W;
          prod_q <= mul_p;
          st_q   <= SC_ADD;
        end
        SC_ADD: begin
          mag_q <= prod_q + rnd_q;
          neg_q <= neg_q ^ sneg_q;
          st_q  <= SC_SAT;
        end
        SC_SAT: begin
          result_q <= sat_val;
          st_q     <= SC_DONE;
        end
        SC_DONE: begin
          if (req_i.ack) begin
            st_q <= SC_IDLE;
          end
        end
        default: st_q <= SC_IDLE;
      endcase
    end
  end

  assign rsp_o.done = (st_q == SC_DONE);
  assign result_o   = result_q;

endmodule

// ----- rtl/signed_codebook_gather_sum.sv -----
// Top level: code, scale and projection stores, slot walk sequencer and result register.
// Load items (code, scale, projection writes) do not hold the input; it is ready again next cycle.
// Compute items walk n = min(slots_in_use, 16) slots, one code read and one projection
// read a cycle through a shared adder; input is held until the result register loads.
// The result register lets a new item enter while a result waits; a stalled output holds
// the next compute at its end. Reset clears control and config; stores have no reset.
module signed_codebook_gather_sum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [scgs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scgs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  scgs_in_if.sink                          in_ch,
  scgs_out_if.source                       out_ch
);
  import scgs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SCALE
  } state_e;

  // Stores
  logic [CODE_W-1:0] code_mem  [ROWS*SLOTS];
  logic [VAL_W-1:0]  scale_mem [ROWS];
  logic [VAL_W-1:0]  proj_mem  [ATOMS];

  // Config
  logic [ATOMS_CFG_W-1:0] atoms_q;
  logic [SLOTS_CFG_W-1:0] slots_q;
  logic                   scale_en_q;

  // Sequencer
  state_e                 state_q;
  logic [ROW_W-1:0]       row_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       n_q;
  logic                   v1_q;
  logic                   take2_q;
  logic                   neg2_q;
  logic signed [SUM_W-1:0] sum_q;

  // Memory read data
  logic [CODE_W-1:0]      code_rd_q;
  logic [VAL_W-1:0]       proj_rd_q;
  logic [VAL_W-1:0]       scale_rd_q;

  // Result register
  logic                   out_valid_q;
  logic [ROW_W-1:0]       out_row_q;
  logic [VAL_W-1:0]       out_sum_q;

  logic                   in_xfer;
  logic                   issue;
  logic                   walk_done;
  logic                   out_free;
  logic                   load_out;
  logic [CNT_W-1:0]       n_next;
  logic [CODE_AW-1:0]     code_raddr;
  logic                   c_neg;
  logic [CODE_W-1:0]      c_mag;
  logic [CODE_W-1:0]      atom;
  logic                   take;
  logic [SUM_W-1:0]       p_ext;
  logic [SUM_W-1:0]       addend;
  scgs_scale_req_t        sreq;
  scgs_scale_rsp_t        srsp;
  logic [VAL_W-1:0]       scaled;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Slot count clamps to the table width
  assign n_next = (CNT_W'(slots_q) > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_q);

  // Walk control
  assign issue      = (state_q == S_WALK) && (cnt_q < n_q);
  assign walk_done  = (state_q == S_WALK) && !issue && !v1_q && !take2_q;
  assign code_raddr = {row_q, cnt_q[SLOT_W-1:0]};

  // Code decode: atom = |code| - 1, skip empty codes and atoms past the limit
  assign c_neg = code_rd_q[CODE_W-1];
  assign c_mag = c_neg ? (~code_rd_q + 1'b1) : code_rd_q;
  assign atom  = c_mag - 1'b1;
  assign take  = v1_q && (code_rd_q != '0)
               && (atom < CODE_W'(atoms_q)) && (atom < CODE_W'(ATOMS));

  // Shared accumulate adder, subtract by inverting with carry in
  assign p_ext  = {{(SUM_W-VAL_W){proj_rd_q[VAL_W-1]}}, proj_rd_q};
  assign addend = neg2_q ? ~p_ext : p_ext;

  // Result register handoff
  assign out_free = !out_valid_q || out_ch.ready;
  assign load_out = (state_q == S_SCALE) && srsp.done && out_free;

  assign sreq.start    = walk_done;
  assign sreq.ack      = load_out;
  assign sreq.scale_en = scale_en_q;

  // Load writes and the scale read for a compute
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      case (scgs_kind_e'(in_ch.kind))
        KIND_CODE:    code_mem[{in_ch.out_row, in_ch.slot}] <= in_ch.code_value;
        KIND_SCALE:   scale_mem[in_ch.out_row] <= in_ch.scale_value;
        KIND_PROJ:    proj_mem[in_ch.atom_index] <= in_ch.proj_value;
        KIND_COMPUTE: scale_rd_q <= scale_mem[in_ch.out_row];
        default: ;
      endcase
    end
  end

  // Walk reads: code at the current slot, projection for the decoded atom
  always_ff @(posedge clk_i) begin
    code_rd_q <= code_mem[code_raddr];
    proj_rd_q <= proj_mem[atom[ATOM_W-1:0]];
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atoms_q    <= ATOMS_CFG_W'(ATOMS_RESET);
      slots_q    <= SLOTS_CFG_W'(SLOTS_RESET);
      scale_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (scgs_cfg_e'(cfg_idx_i))
        CFG_ATOMS:    atoms_q    <= cfg_wdata_i[ATOMS_CFG_W-1:0];
        CFG_SLOTS:    slots_q    <= cfg_wdata_i[SLOTS_CFG_W-1:0];
        CFG_SCALE_EN: scale_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer, accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      sum_q       <= '0;
      v1_q        <= 1'b0;
      take2_q     <= 1'b0;
      neg2_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_sum_q   <= '0;
    end else begin
      v1_q    <= issue;
      take2_q <= take;
      neg2_q  <= c_neg;
      if (out_valid_q && out_ch.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer && (scgs_kind_e'(in_ch.kind) == KIND_COMPUTE)) begin
            row_q   <= in_ch.out_row;
            cnt_q   <= '0;
            n_q     <= n_next;
            sum_q   <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (take2_q) begin
            sum_q <= sum_q + addend + SUM_W'(neg2_q);
          end
          if (walk_done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_row_q   <= row_q;
            out_sum_q   <= scaled;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  scgs_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sreq),
    .sum_i    (sum_q),
    .scale_i  (scale_rd_q),
    .rsp_o    (srsp),
    .result_o (scaled)
  );

  assign out_ch.valid     = out_valid_q;
  assign out_ch.row       = out_row_q;
  assign out_ch.sum_value = out_sum_q;

endmodule

// ----- rtl/scgs_checker.sv -----
// Port-level assertions for the gather-sum top level, attached by bind.
module scgs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [scgs_pkg::KIND_W-1:0]   in_kind_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [scgs_pkg::ROW_W-1:0]    out_row_i,
  input logic [scgs_pkg::VAL_W-1:0]    out_sum_i
);
  import scgs_pkg::*;

  // After a load transfer the input is ready again in the next cycle
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i != KIND_COMPUTE)) |=> in_ready_i)
    else $error("input not ready after a load transfer");

  // A compute transfer occupies the block
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KIND_COMPUTE)) |=> !in_ready_i)
    else $error("input ready right after a compute transfer");

  // A new result only appears at the end of a compute, while input is blocked
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while block was idle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_row_i) && $stable(out_sum_i)))
    else $error("stalled result changed");

endmodule

bind signed_codebook_gather_sum scgs_checker u_scgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_kind_i   (in_ch.kind),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_row_i   (out_ch.row),
  .out_sum_i   (out_ch.sum_value)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the signed codebook gather-sum block.
module testbench;
  import scgs_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // longest compute plus result register, with margin
  localparam int QUIET_LIMIT   = 3000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS   = 90;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    scgs_kind_e               kind;
    logic [ROW_W-1:0]         out_row;
    logic [SLOT_W-1:0]        slot;
    logic [CODE_W-1:0]        code;
    logic [ATOM_W-1:0]        atom;
    logic [VAL_W-1:0]         proj;
    logic [VAL_W-1:0]         scale;
  } gather_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] acc;
  } row_sum_t;

  // Shadow stores, register copy and the queue of row sums still due
  class row_scoreboard;
    logic [CODE_W-1:0] code_tbl [ROWS*SLOTS];
    bit                code_set [ROWS*SLOTS];
    logic [VAL_W-1:0]  scale_tbl [ROWS];
    bit                scale_set [ROWS];
    logic [VAL_W-1:0]  proj_tbl [ATOMS];
    bit                proj_set [ATOMS];
    int                atoms_lim;
    int                slots_lim;
    bit                scale_on;
    row_sum_t          sums_due [$];
    int                errors;

    function new();
      atoms_lim = ATOMS_RESET;
      slots_lim = SLOTS_RESET;
      scale_on  = 1'b0;
      errors    = 0;
      foreach (code_set[i]) code_set[i] = 1'b0;
      foreach (scale_set[i]) scale_set[i] = 1'b0;
      foreach (proj_set[i]) proj_set[i] = 1'b0;
    endfunction

    function int slot_count();
      return (slots_lim < SLOTS) ? slots_lim : SLOTS;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void configure(scgs_cfg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ATOMS:    atoms_lim = int'(val);
        CFG_SLOTS:    slots_lim = int'(val[SLOTS_CFG_W-1:0]);
        CFG_SCALE_EN: scale_on  = val[0];
        default: ;
      endcase
    endfunction

    // Signed gather over the row's slots, optional scale, round and saturate
    function logic [VAL_W-1:0] expected_row_sum(int row);
      int                n;
      longint            acc, c, atom, p, sc;
      longint unsigned   mag, smag;
      bit                neg, sneg;
      n   = slot_count();
      acc = 0;
      for (int s = 0; s < n; s++) begin
        c = longint'($signed(code_tbl[row*SLOTS+s]));
        if (c == 0) continue;
        atom = ((c > 0) ? c : -c) - 1;
        if (atom >= atoms_lim || atom >= ATOMS) continue;
        p = longint'($signed(proj_tbl[atom]));
        acc += (c > 0) ? p : -p;
      end
      neg = acc < 0;
      mag = neg ? -acc : acc;
      if (scale_on) begin
        sc   = longint'($signed(scale_tbl[row]));
        sneg = sc < 0;
        smag = sneg ? -sc : sc;
        // Q32.32 product rounded to Q16.16, ties away from zero
        mag  = (mag >> 16) * smag + (((mag & 64'hFFFF) * smag + 64'h8000) >> 16);
        neg  = neg ^ sneg;
      end
      if (mag == 0) neg = 1'b0;
      if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
      return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function void note_input(gather_item_t it);
      row_sum_t due;
      case (it.kind)
        KIND_CODE: begin
          code_tbl[it.out_row*SLOTS+it.slot] = it.code;
          code_set[it.out_row*SLOTS+it.slot] = 1'b1;
        end
        KIND_SCALE: begin
          scale_tbl[it.out_row] = it.scale;
          scale_set[it.out_row] = 1'b1;
        end
        KIND_PROJ: begin
          proj_tbl[it.atom] = it.proj;
          proj_set[it.atom] = 1'b1;
        end
        default: begin
          due.row = it.out_row;
          due.acc = expected_row_sum(int'(it.out_row));
          sums_due.push_back(due);
        end
      endcase
    endfunction

    function void check_result(logic [ROW_W-1:0] row, logic [VAL_W-1:0] acc);
      row_sum_t due;
      if (sums_due.size() == 0) begin
        $error("unexpected result: row %0d sum_value %h", row, acc);
        errors++;
        return;
      end
      due = sums_due.pop_front();
      if (row !== due.row) begin
        $error("row: expected %0d, got %0d", due.row, row);
        errors++;
      end
      if (acc !== due.acc) begin
        $error("sum_value: expected %h, got %h", due.acc, acc);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  scgs_in_if  in_ch ();
  scgs_out_if out_ch ();

  signed_codebook_gather_sum u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  row_scoreboard sb;
  int unsigned idle_in_pct;
  int unsigned stall_out_pct;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_out_pct);
      end
    end
  end

  // Result check on each output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.row, out_ch.sum_value);
  end

  // Watchdog: counts cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int atom_of(logic [CODE_W-1:0] code);
    int c;
    c = int'($signed(code));
    return (c < 0) ? -c - 1 : c - 1;
  endfunction

  // A row may be computed only when everything it reads has been written
  function automatic bit row_ready(int row);
    int atom;
    for (int s = 0; s < sb.slot_count(); s++) begin
      if (!sb.code_set[row*SLOTS+s]) return 1'b0;
      atom = atom_of(sb.code_tbl[row*SLOTS+s]);
      if (atom >= 0 && atom < ATOMS && !sb.proj_set[atom]) return 1'b0;
    end
    return !sb.scale_on || sb.scale_set[row];
  endfunction

  function automatic gather_item_t noise_item();
    gather_item_t it;
    it.kind    = scgs_kind_e'($urandom_range(3));
    it.out_row = ROW_W'($urandom);
    it.slot    = SLOT_W'($urandom);
    it.code    = CODE_W'($urandom);
    it.atom    = ATOM_W'($urandom);
    it.proj    = $urandom;
    it.scale   = $urandom;
    return it;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r, a;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return CODE_W'($urandom);
    if (r < 30) a = $urandom_range(32767, ATOMS);          // beyond the table
    else if (r < 38) a = sb.atoms_lim - 1 + $urandom_range(1); // around the atom limit
    else if (r < 50) a = 0;
    else if (r < 80) a = $urandom_range(31);
    else a = $urandom_range(ATOMS-1);
    if (a < 0) a = 0;
    if (a > 32767) a = 32767;
    return $urandom_range(1) ? CODE_W'(-(a + 1)) : CODE_W'(a + 1);
  endfunction

  function automatic logic [VAL_W-1:0] pick_proj();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 20) return 32'h8000_0000;
    if (r < 50) return 32'($urandom_range(1 << 19) - (1 << 18));
    return $urandom;
  endfunction

  function automatic logic [VAL_W-1:0] pick_scale();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (r < 25) return $urandom_range(1) ? 32'h0000_8000 : 32'hFFFF_8000;  // one half
    if (r < 55) return 32'($urandom_range(32'h1_1000, 32'h0_F000) * ($urandom_range(1) ? 1 : -1));
    return $urandom;
  endfunction

  // Offer one item, with random idle cycles before it; returns after its transfer
  task automatic send(gather_item_t it);
    if ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_in_pct);
    end
    in_ch.kind        <= it.kind;
    in_ch.out_row     <= it.out_row;
    in_ch.slot        <= it.slot;
    in_ch.code_value  <= it.code;
    in_ch.atom_index  <= it.atom;
    in_ch.proj_value  <= it.proj;
    in_ch.scale_value <= it.scale;
    in_ch.valid       <= 1'b1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic put_code(int row, int slot, logic [CODE_W-1:0] code);
    gather_item_t it;
    it         = noise_item();
    it.kind    = KIND_CODE;
    it.out_row = ROW_W'(row);
    it.slot    = SLOT_W'(slot);
    it.code    = code;
    send(it);
  endtask

  task automatic put_scale(int row, logic [VAL_W-1:0] scale);
    gather_item_t it;
    it         = noise_item();
    it.kind    = KIND_SCALE;
    it.out_row = ROW_W'(row);
    it.scale   = scale;
    send(it);
  endtask

  task automatic put_proj(int atom, logic [VAL_W-1:0] proj);
    gather_item_t it;
    it      = noise_item();
    it.kind = KIND_PROJ;
    it.atom = ATOM_W'(atom);
    it.proj = proj;
    send(it);
  endtask

  task automatic put_compute(int row);
    gather_item_t it;
    it         = noise_item();
    it.kind    = KIND_COMPUTE;
    it.out_row = ROW_W'(row);
    send(it);
  endtask

  // Sender pauses until all sums are back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles
  task automatic apply_config(int unsigned atoms, int unsigned slots, bit scale_en);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ATOMS;
    cfg_wdata_i <= atoms[CFG_DATA_W-1:0];
    @(posedge clk_i);
    sb.configure(CFG_ATOMS, atoms[CFG_DATA_W-1:0]);
    cfg_idx_i   <= CFG_SLOTS;
    cfg_wdata_i <= CFG_DATA_W'(slots[SLOTS_CFG_W-1:0]);
    @(posedge clk_i);
    sb.configure(CFG_SLOTS, CFG_DATA_W'(slots[SLOTS_CFG_W-1:0]));
    cfg_idx_i   <= CFG_SCALE_EN;
    cfg_wdata_i <= CFG_DATA_W'(scale_en);
    @(posedge clk_i);
    sb.configure(CFG_SCALE_EN, CFG_DATA_W'(scale_en));
    cfg_we_i    <= 1'b0;
  endtask

  // One row: some noise items, a few code rewrites, fill whatever the compute reads, then usually compute
  task automatic run_sequence();
    gather_item_t it;
    int row, n, atom;
    row = ($urandom_range(99) < 75) ? $urandom_range(15) : $urandom_range(ROWS-1);
    n   = sb.slot_count();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) begin
        it = noise_item();
        if (it.kind == KIND_COMPUTE && !row_ready(int'(it.out_row)))
          it.kind = scgs_kind_e'($urandom_range(2));
        send(it);
      end
    end
    repeat ($urandom_range(3)) put_code(row, $urandom_range(SLOTS-1), pick_code());
    for (int s = 0; s < n; s++) begin
      if (!sb.code_set[row*SLOTS+s]) put_code(row, s, pick_code());
    end
    for (int s = 0; s < n; s++) begin
      atom = atom_of(sb.code_tbl[row*SLOTS+s]);
      if (atom >= 0 && atom < ATOMS && (!sb.proj_set[atom] || $urandom_range(9) == 0))
        put_proj(atom, pick_proj());
    end
    if ((sb.scale_on && !sb.scale_set[row]) || $urandom_range(3) == 0)
      put_scale(row, pick_scale());
    // some sequences are dropped before the compute
    if ($urandom_range(99) < 90) put_compute(row);
  endtask

  // Main stimulus
  initial begin
    int unsigned phase_end;
    sb            = new();
    idle_in_pct   = 0;
    stall_out_pct = 0;
    hold_left     = 0;
    items_sent    = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_ATOMS;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_CODE;
    in_ch.out_row      <= '0;
    in_ch.slot         <= '0;
    in_ch.code_value   <= '0;
    in_ch.atom_index   <= '0;
    in_ch.proj_value   <= '0;
    in_ch.scale_value  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: saturation both ways, empty slots, codes past the table
    apply_config(ATOMS, 4, 1'b0);
    put_proj(0, 32'h7FFF_FFFF);
    put_proj(1, 32'h8000_0000);
    put_proj(ATOMS-1, 32'h0000_0001);
    put_code(0, 0, 16'sd1);
    put_code(0, 1, 16'sd1);
    put_code(0, 2, 16'sd0);
    put_code(0, 3, 16'sd1024);
    put_compute(0);
    put_code(ROWS-1, 0, 16'sd2);
    put_code(ROWS-1, 1, 16'sd2);
    put_code(ROWS-1, 2, 16'h8000);
    put_code(ROWS-1, 3, 16'h7FFF);
    put_compute(ROWS-1);
    put_code(ROWS-1, 1, -16'sd2);
    put_compute(ROWS-1);

    // Directed: scaling, rounding ties away from zero, scaled saturation
    settle();
    apply_config(ATOMS, 1, 1'b1);
    put_scale(0, 32'h0000_8000);
    put_code(0, 0, 16'sd1024);
    put_compute(0);
    put_code(0, 0, -16'sd1024);
    put_compute(0);
    put_scale(0, 32'h8000_0000);
    put_code(0, 0, 16'sd1);
    put_compute(0);
    put_scale(ROWS-1, 32'h7FFF_FFFF);
    put_compute(ROWS-1);

    // Random phases over several register settings and idle patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: apply_config(ATOMS, SLOTS, 1'b1);
        1: apply_config(1, 1, 1'b0);
        2: apply_config(2047, 31, 1'b1);
        3: apply_config(0, SLOTS, 1'b1);
        4: apply_config($urandom_range(ATOMS-1, 2), 0, 1'b1);
        5: apply_config($urandom_range(ATOMS, 1), $urandom_range(SLOTS, 1), 1'b1);
        6: apply_config(ATOMS, $urandom_range(31), 1'($urandom_range(1)));
        default: apply_config($urandom_range(2047), $urandom_range(31), 1'b1);
      endcase
      case (ph % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 85; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 85; end
        default: begin idle_in_pct = 32; stall_out_pct = 32; end
      endcase
      // receiver holds off while the sender keeps offering
      if (ph == 0) hold_left = HOLD_CYCLES;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_sequence();
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/scgs_pkg.sv
rtl/scgs_if.sv
rtl/scgs_scaler.sv
rtl/signed_codebook_gather_sum.sv
rtl/scgs_checker.sv
test/testbench.sv
